>>> src/pendulum_angle_filter_chain_defines.svh
// Assertion macros for the pendulum angle filter chain.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef PENDULUM_ANGLE_FILTER_CHAIN_DEFINES_SVH
`define PENDULUM_ANGLE_FILTER_CHAIN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PAFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PAFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pafc_pkg.sv
// Package for the pendulum angle filter chain: widths, filter constants,
// sequencer states and the round/saturate helper. No dependencies.
package pafc_pkg;

    localparam int DATA_BITS  = 32;
    localparam int COEF_BITS  = 36;              // nine 4-bit digits
    localparam int DIGIT_BITS = 4;
    localparam int NUM_DIGITS = COEF_BITS / DIGIT_BITS;
    localparam int OPND_BITS  = DATA_BITS + 1;   // data operand, holds a difference
    localparam int PROD_BITS  = COEF_BITS + OPND_BITS + 1;
    localparam int ACC_BITS   = PROD_BITS + 4;
    localparam int NUM_TERMS  = 20;
    localparam int TERM_BITS  = 5;

    // term indexes that close a sum
    localparam logic [TERM_BITS-1:0] T_ANGLE_LAST = 5'd2;
    localparam logic [TERM_BITS-1:0] T_DIFF_LAST  = 5'd3;
    localparam logic [TERM_BITS-1:0] T_RATE_LAST  = 5'd12;
    localparam logic [TERM_BITS-1:0] T_BLEND_LAST = 5'd14;
    localparam logic [TERM_BITS-1:0] T_PRED_LAST  = 5'd19;

    // register indexes
    localparam logic [2:0] R_ANGLE_GATE = 3'd0;
    localparam logic [2:0] R_FRAME_RATE = 3'd1;
    localparam logic [2:0] R_BLEND      = 3'd2;
    localparam logic [2:0] R_PC_INTEG   = 3'd3;
    localparam logic [2:0] R_PC_THETA   = 3'd4;
    localparam logic [2:0] R_PC_ANGLE   = 3'd5;
    localparam logic [2:0] R_PC_TRATE   = 3'd6;
    localparam logic [2:0] R_PC_EST     = 3'd7;

    // filter coefficients, Q16.16, feedback terms already negated
    localparam logic signed [COEF_BITS-1:0] ANG_B0  = 36'sd16069;
    localparam logic signed [COEF_BITS-1:0] ANG_B1  = 36'sd16069;
    localparam logic signed [COEF_BITS-1:0] ANG_NA1 = 36'sd33391;
    localparam logic signed [COEF_BITS-1:0] RT_B0   = 36'sd31287;
    localparam logic signed [COEF_BITS-1:0] RT_B1   = 36'sd60640;
    localparam logic signed [COEF_BITS-1:0] RT_B2   = 36'sd89090;
    localparam logic signed [COEF_BITS-1:0] RT_B3   = 36'sd60640;
    localparam logic signed [COEF_BITS-1:0] RT_B4   = 36'sd31287;
    localparam logic signed [COEF_BITS-1:0] RT_NA1  = -36'sd64094;
    localparam logic signed [COEF_BITS-1:0] RT_NA2  = -36'sd107309;
    localparam logic signed [COEF_BITS-1:0] RT_NA3  = -36'sd40999;
    localparam logic signed [COEF_BITS-1:0] RT_NA4  = -36'sd28318;
    localparam logic signed [COEF_BITS-1:0] ONE_Q16 = 36'sd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_FIN,
        ST_DONE
    } pafc_state_t;

    // divide by 2^16 rounding half up, then saturate to DATA_BITS
    function automatic logic signed [DATA_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] r;
        r = (acc + ACC_BITS'(32768)) >>> 16;
        if (r > ACC_BITS'(2147483647))
            return 32'sh7FFF_FFFF;
        else if (r < ACC_BITS'(-64'sd2147483648))
            return 32'sh8000_0000;
        else
            return r[DATA_BITS-1:0];
    endfunction

endpackage

>>> src/pendulum_angle_filter_chain.sv
// Pendulum angle filter chain top level: angle low-pass, dead band, rate
// filter and rate estimator on one shared digit-serial multiply-accumulate.
// Depends on pafc_pkg and pendulum_angle_filter_chain_defines.svh.
//
// Usage:
//   s_ channel carries one frame per transfer; s_tdata holds, from bit 0 up,
//   angle_meas, angle_rate_meas, theta_integral, theta_pos, theta_rate.
//   m_ channel returns one result per frame; m_tdata holds, from bit 0 up,
//   angle_filtered, angle_gated, angle_rate_diff, angle_rate_filtered,
//   angle_rate_estimate.
//   cfg_wr_en/cfg_index/cfg_wdata write one register per clock; write only
//   while no frame is in flight.
// Sequence: 20 products pass one at a time through a 36x33-bit multiplier
//   that takes a 4-bit coefficient digit per cycle, with a load and an
//   accumulate step per product and a round step per sum; the done state
//   then hands the result off into the output register, raising m_tvalid.
//   The sequencer then returns to idle and only there takes the next frame,
//   so a new frame waits until the last one is through the multiply loop.
// Reset: aresetn low on a clock edge clears the filter histories, the
//   prediction and the result valid, and restores the register defaults.
// Stall: a pending result sits in the output register; a new frame is taken
//   meanwhile, and its result holds in the sequencer until the old one is
//   transferred.
`include "pendulum_angle_filter_chain_defines.svh"

module pendulum_angle_filter_chain
    import pafc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle_meas, angle_rate_meas, theta_integral, theta_pos, theta_rate
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_filtered, angle_gated, angle_rate_diff, angle_rate_filtered,
    // angle_rate_estimate
    output logic [159:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    // configuration
    logic [30:0]        angle_gate_reg;
    logic [9:0]         frame_rate_reg;
    logic [16:0]        blend_weight_reg;
    logic signed [31:0] pc_integ_reg, pc_theta_reg, pc_angle_reg, pc_trate_reg, pc_est_reg;

    // captured frame
    logic signed [31:0] ang_reg, rate_reg, tint_reg, tpos_reg, trate_reg;

    // filter and estimator state
    logic signed [31:0] ang_x1_reg, ang_y1_reg;
    logic signed [31:0] rt_x_reg [4];
    logic signed [31:0] rt_y_reg [4];
    logic signed [31:0] gated_prev_reg, pred_reg;

    // results of this frame
    logic signed [31:0] filt_reg, gated_reg, diff_reg, rfilt_reg, est_reg;

    // sequencer and serial multiplier
    pafc_state_t                 state_reg, state_next;
    logic [TERM_BITS-1:0]        term_reg;
    logic [3:0]                  dig_reg;
    logic signed [COEF_BITS-1:0] coef_sr_reg;
    logic signed [OPND_BITS-1:0] opnd_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;

    logic signed [COEF_BITS-1:0] term_coef;
    logic signed [OPND_BITS-1:0] term_opnd;
    logic                        term_last;
    logic                        out_free;
    logic                        do_mul_first;
    logic signed [4:0]           digit;
    logic signed [OPND_BITS+4:0] part;
    logic signed [DATA_BITS-1:0] sum_rs;
    logic signed [OPND_BITS-1:0] filt_mag;
    logic signed [DATA_BITS-1:0] gated_val;

    assign out_free = !m_tvalid || m_tready;
    assign term_last = (term_reg == T_ANGLE_LAST) || (term_reg == T_DIFF_LAST) ||
                       (term_reg == T_RATE_LAST) || (term_reg == T_BLEND_LAST) ||
                       (term_reg == T_PRED_LAST);

    // select coefficient and operand of the current product
    always_comb begin
        term_coef = '0;
        term_opnd = '0;
        unique case (term_reg)
            5'd0: begin term_coef = ANG_B0;  term_opnd = OPND_BITS'(ang_reg);    end
            5'd1: begin term_coef = ANG_B1;  term_opnd = OPND_BITS'(ang_x1_reg); end
            5'd2: begin term_coef = ANG_NA1; term_opnd = OPND_BITS'(ang_y1_reg); end
            5'd3: begin
                term_coef = $signed({10'b0, frame_rate_reg, 16'b0});
                term_opnd = OPND_BITS'(gated_reg) - OPND_BITS'(gated_prev_reg);
            end
            5'd4:  begin term_coef = RT_B0;  term_opnd = OPND_BITS'(rate_reg);    end
            5'd5:  begin term_coef = RT_B1;  term_opnd = OPND_BITS'(rt_x_reg[0]); end
            5'd6:  begin term_coef = RT_B2;  term_opnd = OPND_BITS'(rt_x_reg[1]); end
            5'd7:  begin term_coef = RT_B3;  term_opnd = OPND_BITS'(rt_x_reg[2]); end
            5'd8:  begin term_coef = RT_B4;  term_opnd = OPND_BITS'(rt_x_reg[3]); end
            5'd9:  begin term_coef = RT_NA1; term_opnd = OPND_BITS'(rt_y_reg[0]); end
            5'd10: begin term_coef = RT_NA2; term_opnd = OPND_BITS'(rt_y_reg[1]); end
            5'd11: begin term_coef = RT_NA3; term_opnd = OPND_BITS'(rt_y_reg[2]); end
            5'd12: begin term_coef = RT_NA4; term_opnd = OPND_BITS'(rt_y_reg[3]); end
            5'd13: begin
                term_coef = ONE_Q16 - $signed({19'b0, blend_weight_reg});
                term_opnd = OPND_BITS'(pred_reg);
            end
            5'd14: begin
                term_coef = $signed({19'b0, blend_weight_reg});
                term_opnd = OPND_BITS'(rate_reg);
            end
            5'd15: begin term_coef = COEF_BITS'(pc_integ_reg); term_opnd = OPND_BITS'(tint_reg); end
            5'd16: begin term_coef = COEF_BITS'(pc_theta_reg); term_opnd = OPND_BITS'(tpos_reg); end
            5'd17: begin term_coef = COEF_BITS'(pc_angle_reg); term_opnd = OPND_BITS'(ang_reg); end
            5'd18: begin term_coef = COEF_BITS'(pc_trate_reg); term_opnd = OPND_BITS'(trate_reg); end
            5'd19: begin term_coef = COEF_BITS'(pc_est_reg); term_opnd = OPND_BITS'(est_reg); end
            default: begin term_coef = '0; term_opnd = '0; end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:  if (dig_reg == 4'(NUM_DIGITS - 1)) state_next = ST_ADD;
            ST_ADD:  state_next = term_last ? ST_FIN : ST_LOAD;
            ST_FIN:  state_next = (term_reg == T_PRED_LAST) ? ST_DONE : ST_LOAD;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        do_mul_first = (state_reg == ST_MUL) && (dig_reg == 4'd0);
    end

    // digit step: top digit signed, the rest unsigned
    assign digit = do_mul_first ? $signed({coef_sr_reg[COEF_BITS-1],
                                           coef_sr_reg[COEF_BITS-1 -: DIGIT_BITS]})
                                : $signed({1'b0, coef_sr_reg[COEF_BITS-1 -: DIGIT_BITS]});
    assign part = opnd_reg * digit;
    assign sum_rs = round_sat(acc_reg);
    assign filt_mag = sum_rs[DATA_BITS-1] ? -OPND_BITS'(sum_rs) : OPND_BITS'(sum_rs);
    assign gated_val = (filt_mag < $signed({2'b0, angle_gate_reg})) ? '0 : sum_rs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_tvalid         <= 1'b0;
            angle_gate_reg   <= 31'd262;
            frame_rate_reg   <= 10'd60;
            blend_weight_reg <= 17'd53844;
            pc_integ_reg     <= '0;
            pc_theta_reg     <= '0;
            pc_angle_reg     <= '0;
            pc_trate_reg     <= '0;
            pc_est_reg       <= 32'sd65536;
            ang_x1_reg       <= '0;
            ang_y1_reg       <= '0;
            for (int i = 0; i < 4; i++) begin
                rt_x_reg[i] <= '0;
                rt_y_reg[i] <= '0;
            end
            gated_prev_reg   <= '0;
            pred_reg         <= '0;
            term_reg         <= '0;
            dig_reg          <= '0;
            acc_reg          <= '0;
        end else begin
            state_reg <= state_next;
            // raise valid on hand-off, drop it once the result is transferred
            if (state_reg == ST_DONE && out_free) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    R_ANGLE_GATE: angle_gate_reg   <= cfg_wdata[30:0];
                    R_FRAME_RATE: frame_rate_reg   <= cfg_wdata[9:0];
                    R_BLEND:      blend_weight_reg <= cfg_wdata[16:0];
                    R_PC_INTEG:   pc_integ_reg     <= cfg_wdata;
                    R_PC_THETA:   pc_theta_reg     <= cfg_wdata;
                    R_PC_ANGLE:   pc_angle_reg     <= cfg_wdata;
                    R_PC_TRATE:   pc_trate_reg     <= cfg_wdata;
                    R_PC_EST:     pc_est_reg       <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    term_reg <= '0;
                    acc_reg  <= '0;
                    if (s_tvalid) begin
                        ang_reg   <= s_tdata[31:0];
                        rate_reg  <= s_tdata[63:32];
                        tint_reg  <= s_tdata[95:64];
                        tpos_reg  <= s_tdata[127:96];
                        trate_reg <= s_tdata[159:128];
                    end
                end
                ST_LOAD: begin
                    coef_sr_reg <= term_coef;
                    opnd_reg    <= term_opnd;
                    prod_reg    <= '0;
                    dig_reg     <= '0;
                end
                ST_MUL: begin
                    // Horner from the top digit
                    prod_reg    <= (prod_reg <<< DIGIT_BITS) + PROD_BITS'(part);
                    coef_sr_reg <= coef_sr_reg << DIGIT_BITS;
                    dig_reg     <= dig_reg + 4'd1;
                end
                ST_ADD: begin
                    acc_reg <= acc_reg + ACC_BITS'(prod_reg);
                    if (!term_last) term_reg <= term_reg + 5'd1;
                end
                ST_FIN: begin
                    acc_reg  <= '0;
                    term_reg <= term_reg + 5'd1;
                    priority case (term_reg)
                        T_ANGLE_LAST: begin
                            filt_reg  <= sum_rs;
                            gated_reg <= gated_val;
                        end
                        T_DIFF_LAST:  diff_reg  <= sum_rs;
                        T_RATE_LAST:  rfilt_reg <= sum_rs;
                        T_BLEND_LAST: est_reg   <= sum_rs;
                        default:      pred_reg  <= sum_rs;
                    endcase
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata        <= {est_reg, rfilt_reg, diff_reg, gated_reg, filt_reg};
                        ang_x1_reg     <= ang_reg;
                        ang_y1_reg     <= filt_reg;
                        rt_x_reg[0]    <= rate_reg;
                        rt_y_reg[0]    <= rfilt_reg;
                        for (int i = 1; i < 4; i++) begin
                            rt_x_reg[i] <= rt_x_reg[i-1];
                            rt_y_reg[i] <= rt_y_reg[i-1];
                        end
                        gated_prev_reg <= gated_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    `PAFC_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_LOAD, "frame not started")
    `PAFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `PAFC_ASSERT_IMPL(a_fin_at_end, state_reg == ST_FIN, term_last, "round outside sum end")
    `PAFC_ASSERT_IMPL(a_mul_digits, state_reg == ST_MUL, dig_reg < 4'(NUM_DIGITS), "digit overrun")

endmodule
